// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the box overlap ratio rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BIOU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BIOU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/biou_pkg.sv =====
// shared widths, payload types and corner helpers for the box overlap ratio core
package biou_pkg;

  localparam int COORD_W   = 16;              // input field width
  localparam int FRAC_BITS = 15;              // fraction bits of the ratio
  localparam int RATIO_W   = 16;              // output ratio width
  localparam int CORNER_W  = COORD_W + 3;     // signed doubled corner
  localparam int OVL_W     = COORD_W + 1;     // doubled overlap length
  localparam int INTER_W   = 2 * OVL_W;       // intersection area (x4)
  localparam int AREA_W    = 2 * COORD_W + 2; // box area (x4)
  localparam int UNI_W     = AREA_W + 1;      // union area (x4)
  localparam int REM_W     = UNI_W;           // divider remainder
  localparam int QUOT_W    = FRAC_BITS + 1;   // ratio never exceeds 1.0

  localparam logic [QUOT_W-1:0]  QUOT_ONE  = QUOT_W'(1) << FRAC_BITS;
  localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

  typedef logic [COORD_W-1:0]         coord_t;
  typedef logic signed [CORNER_W-1:0] corner_t;

  // one box pair, first field in the highest bits
  typedef struct packed {
    coord_t b_height;
    coord_t b_width;
    coord_t b_center_y;
    coord_t b_center_x;
    coord_t a_height;
    coord_t a_width;
    coord_t a_center_y;
    coord_t a_center_x;
  } biou_pair_t;

  // areas handed from the geometry front end to the divider
  typedef struct packed {
    logic               degen;
    logic [UNI_W-1:0]   uni;
    logic [INTER_W-1:0] inter;
  } biou_frac_t;

  // divider result
  typedef struct packed {
    logic              degen;
    logic [QUOT_W-1:0] quot;
  } biou_quot_t;

  // doubled low corner: 2*c - s
  function automatic corner_t corner_lo(coord_t c, coord_t s);
    return $signed({2'b00, c, 1'b0}) - $signed({3'b000, s});
  endfunction

  // doubled high corner: 2*c + s
  function automatic corner_t corner_hi(coord_t c, coord_t s);
    return $signed({2'b00, c, 1'b0}) + $signed({3'b000, s});
  endfunction

  // overlap of two doubled intervals, clamped at zero
  function automatic logic [OVL_W-1:0] overlap(corner_t alo, corner_t ahi,
                                               corner_t blo, corner_t bhi);
    corner_t                   hi;
    corner_t                   lo;
    logic signed [CORNER_W:0]  d;
    hi = (ahi < bhi) ? ahi : bhi;
    lo = (alo > blo) ? alo : blo;
    d  = {hi[CORNER_W-1], hi} - {lo[CORNER_W-1], lo};
    return (d > 0) ? OVL_W'(d) : '0;
  endfunction

endpackage

// ===== rtl/core/box_intersection_over_union.sv =====
// path from input transaction to result: geometry front end, divider pipeline, output register
// throughput: one box pair per cycle while out_tready does not stall the pipe, set by the one-bit-per-stage divider
// pipeline; every stage holds on a stall, a bubble in the pipe is filled while the output waits
// reset: synchronous active-low rst_n clears all valid bits, the pipe comes up empty
// top level: box pair in, intersection over union out
`include "assert_macros.svh"

module box_intersection_over_union (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_center_x, a_center_y, a_width, a_height, b_center_x, b_center_y, b_width, b_height
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // overlap_ratio
  output logic [15:0]  out_tdata,
  // degenerate
  output logic [0:0]   out_tuser
);
  import biou_pkg::*;

  localparam int WIDE_W = QUOT_W + RATIO_W;

  biou_pair_t pair;
  logic       geom_valid, geom_ready;
  biou_frac_t frac;
  logic       div_valid, div_ready;
  biou_quot_t quot;

  logic               out_v_r;
  logic [RATIO_W-1:0] ratio_r, ratio_nxt;
  logic               degen_r;
  logic [WIDE_W-1:0]  quot_wide;

  assign pair = biou_pair_t'(in_tdata);

  biou_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pair   (pair),
    .out_valid (geom_valid),
    .out_ready (geom_ready),
    .out_frac  (frac)
  );

  biou_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (geom_valid),
    .in_ready  (geom_ready),
    .in_frac   (frac),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_quot  (quot)
  );

  // saturate and zero the ratio on an empty union
  assign quot_wide = WIDE_W'(quot.quot);
  always_comb begin
    if (quot.degen) begin
      ratio_nxt = '0;
    end else if (quot_wide > WIDE_W'(RATIO_MAX)) begin
      ratio_nxt = RATIO_MAX;
    end else begin
      ratio_nxt = quot_wide[RATIO_W-1:0];
    end
  end

  // output register
  assign div_ready = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (div_ready) begin
      out_v_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      ratio_r <= ratio_nxt;
      degen_r <= quot.degen;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = ratio_r;
  assign out_tuser  = degen_r;

  // a degenerate transaction always carries a zero ratio
  `BIOU_ASSERT_NOW(a_degen_zero_ratio, out_v_r && degen_r, ratio_r == '0,
                   "degenerate result with nonzero ratio")

endmodule

// ===== rtl/core/biou_geom.sv =====
// geometry front end: corners, overlaps, areas and union in four stages
`include "assert_macros.svh"

module biou_geom (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  biou_pkg::biou_pair_t in_pair,
  output logic                out_valid,
  input  logic                out_ready,
  output biou_pkg::biou_frac_t out_frac
);
  import biou_pkg::*;

  // stage enables, a stage moves when empty or when the next one moves
  logic en1, en2, en3, en4;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;

  // stage 1: doubled corners
  corner_t ax_lo_r, ax_hi_r, bx_lo_r, bx_hi_r;
  corner_t ay_lo_r, ay_hi_r, by_lo_r, by_hi_r;
  coord_t  s1_aw_r, s1_ah_r, s1_bw_r, s1_bh_r;

  // stage 2: overlap lengths
  logic [OVL_W-1:0] iw_r, ih_r;
  coord_t           s2_aw_r, s2_ah_r, s2_bw_r, s2_bh_r;

  // stage 3: areas
  logic [INTER_W-1:0]   s3_inter_r;
  logic [AREA_W-1:0]    area_a_r, area_b_r;
  logic [2*COORD_W-1:0] prod_a_nxt, prod_b_nxt;

  // stage 4: union
  logic [INTER_W-1:0] s4_inter_r;
  logic [UNI_W-1:0]   s4_uni_r, uni_nxt;
  logic               s4_degen_r;

  assign en4 = !s4_v_r || out_ready;
  assign en3 = !s3_v_r || en4;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;
  assign in_ready = en1;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= in_valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en4) s4_v_r <= s3_v_r;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (en1) begin
      ax_lo_r <= corner_lo(in_pair.a_center_x, in_pair.a_width);
      ax_hi_r <= corner_hi(in_pair.a_center_x, in_pair.a_width);
      bx_lo_r <= corner_lo(in_pair.b_center_x, in_pair.b_width);
      bx_hi_r <= corner_hi(in_pair.b_center_x, in_pair.b_width);
      ay_lo_r <= corner_lo(in_pair.a_center_y, in_pair.a_height);
      ay_hi_r <= corner_hi(in_pair.a_center_y, in_pair.a_height);
      by_lo_r <= corner_lo(in_pair.b_center_y, in_pair.b_height);
      by_hi_r <= corner_hi(in_pair.b_center_y, in_pair.b_height);
      s1_aw_r <= in_pair.a_width;
      s1_ah_r <= in_pair.a_height;
      s1_bw_r <= in_pair.b_width;
      s1_bh_r <= in_pair.b_height;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (en2) begin
      iw_r    <= overlap(ax_lo_r, ax_hi_r, bx_lo_r, bx_hi_r);
      ih_r    <= overlap(ay_lo_r, ay_hi_r, by_lo_r, by_hi_r);
      s2_aw_r <= s1_aw_r;
      s2_ah_r <= s1_ah_r;
      s2_bw_r <= s1_bw_r;
      s2_bh_r <= s1_bh_r;
    end
  end

  // stage 3: three multipliers in parallel
  assign prod_a_nxt = s2_aw_r * s2_ah_r;
  assign prod_b_nxt = s2_bw_r * s2_bh_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_inter_r <= iw_r * ih_r;
      area_a_r   <= {prod_a_nxt, 2'b00};
      area_b_r   <= {prod_b_nxt, 2'b00};
    end
  end

  // stage 4: union = a + b - inter, cannot wrap since inter <= min area
  assign uni_nxt = UNI_W'(area_a_r) + UNI_W'(area_b_r) - UNI_W'(s3_inter_r);

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_inter_r <= s3_inter_r;
      s4_uni_r   <= uni_nxt;
      s4_degen_r <= (uni_nxt == '0);
    end
  end

  assign out_valid      = s4_v_r;
  assign out_frac.inter = s4_inter_r;
  assign out_frac.uni   = s4_uni_r;
  assign out_frac.degen = s4_degen_r;

  // an empty union leaves no intersection behind
  `BIOU_ASSERT_NOW(a_empty_union_no_inter, s4_v_r && s4_degen_r, s4_inter_r == '0,
                   "zero union with nonzero intersection")

endmodule

// ===== rtl/core/biou_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`include "assert_macros.svh"

module biou_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  biou_pkg::biou_frac_t in_frac,
  output logic                 out_valid,
  input  logic                 out_ready,
  output biou_pkg::biou_quot_t out_quot
);
  import biou_pkg::*;

  logic [QUOT_W:0]    en;
  logic               v_r     [QUOT_W];
  logic [REM_W-1:0]   rem_r   [QUOT_W];
  logic [UNI_W-1:0]   den_r   [QUOT_W];
  logic [QUOT_W-1:0]  q_r     [QUOT_W];
  logic               degen_r [QUOT_W];

  assign en[QUOT_W] = out_ready;
  assign in_ready   = en[0];

  for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
    logic              src_v;
    logic [REM_W:0]    src_x;
    logic [UNI_W-1:0]  src_den;
    logic [QUOT_W-1:0] src_q;
    logic              src_degen;
    logic              ge;
    logic [REM_W:0]    diff;
    logic [REM_W-1:0]  rem_nxt;
    logic [QUOT_W-1:0] q_nxt;

    // first stage takes the dividend as is, later ones the doubled remainder
    if (s == 0) begin : g_first
      assign src_v     = in_valid;
      assign src_x     = (REM_W + 1)'(in_frac.inter);
      assign src_den   = in_frac.uni;
      assign src_q     = '0;
      assign src_degen = in_frac.degen;
    end else begin : g_next
      assign src_v     = v_r[s-1];
      assign src_x     = {rem_r[s-1], 1'b0};
      assign src_den   = den_r[s-1];
      assign src_q     = q_r[s-1];
      assign src_degen = degen_r[s-1];
    end

    // compare and subtract
    assign diff    = src_x - (REM_W + 1)'(src_den);
    assign ge      = (src_x >= (REM_W + 1)'(src_den));
    assign rem_nxt = ge ? diff[REM_W-1:0] : src_x[REM_W-1:0];
    assign q_nxt   = {src_q[QUOT_W-2:0], ge};

    assign en[s] = !v_r[s] || en[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s]   <= rem_nxt;
        den_r[s]   <= src_den;
        q_r[s]     <= q_nxt;
        degen_r[s] <= src_degen;
      end
    end
  end

  assign out_valid      = v_r[QUOT_W-1];
  assign out_quot.quot  = q_r[QUOT_W-1];
  assign out_quot.degen = degen_r[QUOT_W-1];

  // intersection never exceeds union, so the quotient stays at or below one
  `BIOU_ASSERT_NOW(a_quot_at_most_one, v_r[QUOT_W-1] && !degen_r[QUOT_W-1],
                   q_r[QUOT_W-1] <= QUOT_ONE, "quotient above 1.0")

  // a held result in the last stage stays put
  `BIOU_ASSERT_NEXT(a_last_stage_holds, v_r[QUOT_W-1] && !out_ready,
                    v_r[QUOT_W-1] && $stable(q_r[QUOT_W-1]), "stalled quotient changed")

endmodule
